// ===== rtl/brf_pkg.sv =====
package brf_pkg;

    // Store geometry. Pointers carry one extra bit so that full and empty differ.
    localparam int DEPTH    = 4096;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PTR_W    = ADDR_W + 1;
    localparam int MAX_PEEK = 64;
    localparam int RUN_W    = $clog2(MAX_PEEK + 1);

    // Field widths of the item and result beats.
    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 13;
    localparam int STAT_W   = 2;
    localparam int FILL_W   = 13;
    localparam int RES_RUN_W = 7;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET_ACT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INACTIVE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_CLAMPED  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] count;
        logic               active_flag;
    } t_brf_item;

    typedef struct packed {
        logic [BYTE_W-1:0]    data_out;
        logic [RES_RUN_W-1:0] run_length;
        logic                 last;
        logic [STAT_W-1:0]    status;
        logic [FILL_W-1:0]    fill_level;
    } t_brf_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic issue;
    } t_brf_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic peek_go;
        logic last_issue;
    } t_brf_sts;

endpackage

// ===== rtl/brf_ctrl.sv =====
module brf_ctrl
    import brf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_brf_sts i_sts,
    output t_brf_cmd o_cmd,
    output logic     busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PEEK = 1'b1;

    logic r_state;
    logic n_state;

    // An item is taken only in the idle state; a peek run issues one read a cycle.
    always_comb begin
        o_cmd.accept = 1'b0;
        o_cmd.issue  = 1'b0;
        n_state      = r_state;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = start;
                if (start && i_sts.peek_go) begin
                    n_state = ST_PEEK;
                end
            end
            ST_PEEK: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state == ST_PEEK);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/brf_dpath.sv =====
module brf_dpath
    import brf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_brf_item   i_item,
    input  t_brf_cmd    i_cmd,
    output t_brf_sts    o_sts,
    output t_brf_result o_result,
    output logic        o_strobe
);

    logic [BYTE_W-1:0] r_mem [DEPTH];

    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic              r_active, n_active;
    logic [RUN_W-1:0]  r_run;
    logic [RUN_W-1:0]  r_idx;
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic              r_res_vld;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [FILL_W-1:0] r_res_fill;
    logic              n_res_vld;

    logic [PTR_W-1:0]   fill;
    logic [PTR_W-1:0]   fill_after;
    logic [RUN_W-1:0]   cnt_cap;
    logic [RUN_W-1:0]   n_peek;
    logic               mem_we;
    logic [ADDR_W-1:0]  rd_addr;

    // Fill level from the pointer difference; the wrap of the extra bit does the modulo.
    assign fill = r_wp - r_rp;

    // Peek length: the count capped at the run limit, then at the fill level.
    always_comb begin
        if (i_item.count > COUNT_W'(MAX_PEEK)) begin
            cnt_cap = RUN_W'(MAX_PEEK);
        end else begin
            cnt_cap = i_item.count[RUN_W-1:0];
        end
        if (PTR_W'(cnt_cap) > fill) begin
            n_peek = fill[RUN_W-1:0];
        end else begin
            n_peek = cnt_cap;
        end
    end

    assign o_sts.peek_go    = (i_item.kind == KIND_PEEK) && r_active && (n_peek != '0);
    assign o_sts.last_issue = ((r_idx + RUN_W'(1)) == r_run);

    // Next state of the pointers and the single-beat result for an accepted item that starts no peek run.
    always_comb begin
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_active     = r_active;
        n_res_vld    = 1'b0;
        n_res_status = STAT_OK;
        mem_we       = 1'b0;
        if (i_cmd.accept) begin
            n_res_vld = 1'b1;
            case (i_item.kind)
                KIND_WRITE: begin
                    if (!r_active) begin
                        n_res_status = STAT_INACTIVE;
                    end else if (fill >= PTR_W'(DEPTH)) begin
                        n_res_status = STAT_FULL;
                    end else begin
                        mem_we = 1'b1;
                        n_wp   = r_wp + PTR_W'(1);
                    end
                end
                KIND_PEEK: begin
                    if (!r_active) begin
                        n_res_status = STAT_INACTIVE;
                    end else if (n_peek != '0) begin
                        n_res_vld = 1'b0;
                    end
                end
                KIND_ADVANCE: begin
                    if (!r_active) begin
                        n_res_status = STAT_INACTIVE;
                    end else if (PTR_W'(i_item.count) > fill) begin
                        n_rp         = r_wp;
                        n_res_status = STAT_CLAMPED;
                    end else begin
                        n_rp = r_rp + PTR_W'(i_item.count);
                    end
                end
                KIND_SET_ACT: begin
                    n_active = i_item.active_flag;
                    if (!i_item.active_flag) begin
                        n_rp = '0;
                        n_wp = '0;
                    end
                end
                KIND_CLEAR: begin
                    n_rp = '0;
                    n_wp = '0;
                end
                default: begin
                    n_res_status = STAT_OK;
                end
            endcase
        end
    end

    assign fill_after = n_wp - n_rp;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp      <= '0;
            r_wp      <= '0;
            r_active  <= 1'b0;
            r_res_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rp      <= n_rp;
            r_wp      <= n_wp;
            r_active  <= n_active;
            r_res_vld <= n_res_vld;
            r_rd_vld  <= i_cmd.issue;
        end
    end

    // Result payload and peek run bookkeeping.
    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_fill   <= FILL_W'(fill_after);
        r_rd_last    <= o_sts.last_issue;
        if (i_cmd.accept) begin
            r_run <= n_peek;
            r_idx <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + RUN_W'(1);
        end
    end

    // Byte store: one write port at the write pointer, one registered read port.
    assign rd_addr = r_rp[ADDR_W-1:0] + ADDR_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp[ADDR_W-1:0]] <= i_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
    end

    // A peeked byte beat and a single result beat never fall in the same cycle.
    always_comb begin
        if (r_rd_vld) begin
            o_result.data_out   = r_rd_data;
            o_result.run_length = RES_RUN_W'(r_run);
            o_result.last       = r_rd_last;
            o_result.status     = STAT_OK;
            o_result.fill_level = FILL_W'(fill);
        end else begin
            o_result.data_out   = '0;
            o_result.run_length = '0;
            o_result.last       = 1'b1;
            o_result.status     = r_res_status;
            o_result.fill_level = r_res_fill;
        end
    end

    assign o_strobe = r_rd_vld | r_res_vld;

endmodule

// ===== rtl/byte_ring_fifo_peek_advance.sv =====
// Channel   Ports                     Beat taken when
// item      start, busy, i_item       start high and busy low at a rising edge
// result    o_strobe, o_result        o_strobe high, for one cycle only
//
// A write, advance, set active, clear or refused item gives its result in the cycle
// after it is taken, and busy stays low, so such items can follow every cycle.
// A peek of n bytes holds busy while the store is read one byte a cycle
// through its single registered read port; each byte follows in the cycle after its read.
// Reset is synchronous and clears the pointers and the active flag; the byte
// store is not cleared. The receiver cannot stall the result beats.
module byte_ring_fifo_peek_advance
    import brf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_brf_item   i_item,
    output logic        busy,
    output t_brf_result o_result,
    output logic        o_strobe
);

    t_brf_cmd cmd;
    t_brf_sts sts;

    // Sequencer for item acceptance and peek runs.
    brf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Pointers, byte store and result registers.
    brf_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule

// ===== test/byte_ring_fifo_peek_advance_tb.sv =====
`timescale 1ns / 1ps

module byte_ring_fifo_peek_advance_tb;
    import brf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 2 * MAX_PEEK + 8;

    typedef enum {GAP_NONE, GAP_SHORT, GAP_MIXED} t_gap_style;

    // Tracks the ring contents and pointers, and queues the result beats that each
    // accepted item should produce.
    class ring_fifo_tracker;
        logic [BYTE_W-1:0] ring_mem [DEPTH];
        logic [PTR_W-1:0]  rd_ptr;
        logic [PTR_W-1:0]  wr_ptr;
        logic              active;
        t_brf_result       pending_results [$];
        int                errors;

        function new();
            rd_ptr = '0;
            wr_ptr = '0;
            active = 1'b0;
            errors = 0;
        endfunction

        function int held();
            logic [PTR_W-1:0] diff;
            diff = wr_ptr - rd_ptr;
            return int'(diff);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function string show(t_brf_result r);
            return $sformatf("data_out=%h run_length=%0d last=%b status=%0d fill_level=%0d",
                             r.data_out, r.run_length, r.last, r.status, r.fill_level);
        endfunction

        // The fill level is taken after the item has updated the pointers.
        function void push_result(logic [BYTE_W-1:0] data, int run, logic last,
                                  logic [STAT_W-1:0] status);
            t_brf_result r;
            r.data_out   = data;
            r.run_length = RES_RUN_W'(run);
            r.last       = last;
            r.status     = status;
            r.fill_level = FILL_W'(held());
            pending_results.push_back(r);
        endfunction

        function void take_item(t_brf_item it);
            int                fill;
            int                n;
            logic [PTR_W-1:0]  p;
            logic [STAT_W-1:0] stat;
            fill = held();
            case (it.kind)
                KIND_WRITE: begin
                    if (!active) begin
                        push_result('0, 0, 1'b1, STAT_INACTIVE);
                    end else if (fill >= DEPTH) begin
                        push_result('0, 0, 1'b1, STAT_FULL);
                    end else begin
                        ring_mem[wr_ptr[ADDR_W-1:0]] = it.data_byte;
                        wr_ptr = wr_ptr + 1'b1;
                        push_result('0, 0, 1'b1, STAT_OK);
                    end
                end
                KIND_PEEK: begin
                    // A peek reads the oldest bytes without moving the read pointer.
                    n = int'(it.count);
                    if (n > MAX_PEEK) n = MAX_PEEK;
                    if (n > fill) n = fill;
                    if (!active) begin
                        push_result('0, 0, 1'b1, STAT_INACTIVE);
                    end else if (n == 0) begin
                        push_result('0, 0, 1'b1, STAT_OK);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            p = rd_ptr + PTR_W'(i);
                            push_result(ring_mem[p[ADDR_W-1:0]], n, (i == n - 1), STAT_OK);
                        end
                    end
                end
                KIND_ADVANCE: begin
                    // Advancing past the fill level empties the ring and flags it.
                    if (!active) begin
                        push_result('0, 0, 1'b1, STAT_INACTIVE);
                    end else begin
                        n    = int'(it.count);
                        stat = STAT_OK;
                        if (n > fill) begin
                            n    = fill;
                            stat = STAT_CLAMPED;
                        end
                        rd_ptr = rd_ptr + PTR_W'(n);
                        push_result('0, 0, 1'b1, stat);
                    end
                end
                KIND_SET_ACT: begin
                    active = it.active_flag;
                    if (!it.active_flag) begin
                        rd_ptr = '0;
                        wr_ptr = '0;
                    end
                    push_result('0, 0, 1'b1, STAT_OK);
                end
                KIND_CLEAR: begin
                    rd_ptr = '0;
                    wr_ptr = '0;
                    push_result('0, 0, 1'b1, STAT_OK);
                end
                default: begin
                    push_result('0, 0, 1'b1, STAT_OK);
                end
            endcase
        endfunction

        function void match_result(t_brf_result got);
            t_brf_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %s",
                         $time, show(got));
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: result mismatch, expected %s, actual %s",
                         $time, show(want), show(got));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    t_brf_item   i_item;
    logic        busy;
    t_brf_result o_result;
    logic        o_strobe;

    ring_fifo_tracker ledger;
    t_gap_style       gap_style;
    int               beats_issued = 0;
    int               cycle_count  = 0;

    byte_ring_fifo_peek_advance u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Item beats are noted and result beats checked at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) ledger.take_item(i_item);
            if (o_strobe) ledger.match_result(o_result);
        end
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [BYTE_W-1:0] any_byte();
        return BYTE_W'($urandom);
    endfunction

    function automatic logic [COUNT_W-1:0] any_count();
        return COUNT_W'($urandom);
    endfunction

    function automatic logic any_flag();
        return 1'($urandom);
    endfunction

    function automatic int pick_gap();
        int r;
        if (gap_style == GAP_NONE) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (gap_style == GAP_SHORT || r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic issue(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                         input logic [COUNT_W-1:0] count, input logic flag);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{kind: kind, data_byte: data, count: count, active_flag: flag};
        do @(posedge i_clk); while (busy);
        beats_issued++;
        @(negedge i_clk);
    endtask

    task automatic issue_random_item();
        int                 r;
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        r = $urandom_range(0, 99);
        if (r < 40)      kind = KIND_WRITE;
        else if (r < 60) kind = KIND_PEEK;
        else if (r < 80) kind = KIND_ADVANCE;
        else if (r < 88) kind = KIND_SET_ACT;
        else if (r < 94) kind = KIND_CLEAR;
        else             kind = KIND_W'($urandom_range(5, 7));
        count = ($urandom_range(0, 3) == 0) ? any_count() : COUNT_W'($urandom_range(0, 80));
        issue(kind, any_byte(), count, ($urandom_range(0, 5) != 0));
    endtask

    // Fill the ring until a write is refused.
    task automatic fill_to_refusal();
        while (ledger.held() < DEPTH) issue(KIND_WRITE, any_byte(), any_count(), any_flag());
        issue(KIND_WRITE, any_byte(), any_count(), any_flag());
    endtask

    initial begin
        int r;
        int k;
        int stop_at;
        ledger    = new();
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_item    = '0;
        gap_style = GAP_MIXED;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: inactive refusals, empty and zero-count peeks, capped peeks,
        // clamped advance, unused kinds, clear and deactivation.
        issue(KIND_PEEK, any_byte(), 13'd5, any_flag());
        issue(KIND_WRITE, 8'h00, any_count(), any_flag());
        issue(KIND_ADVANCE, any_byte(), 13'd1, any_flag());
        issue(KIND_SET_ACT, any_byte(), any_count(), 1'b1);
        issue(KIND_PEEK, any_byte(), 13'd5, any_flag());
        issue(KIND_WRITE, 8'h00, any_count(), any_flag());
        issue(KIND_WRITE, 8'hFF, any_count(), any_flag());
        issue(KIND_WRITE, 8'hA5, any_count(), any_flag());
        issue(KIND_PEEK, any_byte(), 13'd0, any_flag());
        issue(KIND_PEEK, any_byte(), 13'h1FFF, any_flag());
        issue(KIND_PEEK, any_byte(), 13'd2, any_flag());
        issue(KIND_ADVANCE, any_byte(), 13'd1, any_flag());
        issue(KIND_ADVANCE, any_byte(), 13'h1FFF, any_flag());
        issue(3'd5, any_byte(), any_count(), any_flag());
        issue(3'd6, any_byte(), any_count(), any_flag());
        issue(3'd7, any_byte(), any_count(), any_flag());
        issue(KIND_WRITE, 8'h3C, any_count(), any_flag());
        issue(KIND_WRITE, 8'hC3, any_count(), any_flag());
        issue(KIND_CLEAR, any_byte(), any_count(), any_flag());
        issue(KIND_PEEK, any_byte(), 13'd4, any_flag());
        issue(KIND_WRITE, 8'h5A, any_count(), any_flag());
        issue(KIND_SET_ACT, any_byte(), any_count(), 1'b0);
        issue(KIND_WRITE, 8'h77, any_count(), any_flag());
        issue(KIND_CLEAR, any_byte(), any_count(), any_flag());
        issue(KIND_SET_ACT, any_byte(), any_count(), 1'b1);

        // Full ring, a peek that ends at the last byte of the store, and pointer wrap.
        gap_style = GAP_SHORT;
        fill_to_refusal();
        issue(KIND_PEEK, any_byte(), 13'd64, any_flag());
        issue(KIND_ADVANCE, any_byte(), 13'd4090, any_flag());
        issue(KIND_PEEK, any_byte(), 13'd64, any_flag());
        fill_to_refusal();
        issue(KIND_ADVANCE, any_byte(), 13'd100, any_flag());
        fill_to_refusal();
        issue(KIND_PEEK, any_byte(), 13'd100, any_flag());
        issue(KIND_PEEK, any_byte(), 13'd65, any_flag());
        issue(KIND_ADVANCE, any_byte(), 13'd4096, any_flag());
        issue(KIND_PEEK, any_byte(), 13'd1, any_flag());
        issue(KIND_WRITE, any_byte(), any_count(), any_flag());
        issue(KIND_ADVANCE, any_byte(), 13'd5000, any_flag());

        // Random: write runs followed by a peek and an advance in half the rounds, with stray
        // items and control beats in the rest.
        stop_at = beats_issued + RANDOM_ITEMS;
        while (beats_issued < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 15)      gap_style = GAP_NONE;
            else if (r < 30) gap_style = GAP_SHORT;
            else             gap_style = GAP_MIXED;
            r = $urandom_range(0, 99);
            if (r < 50) begin
                if (!ledger.active && $urandom_range(0, 4) != 0) begin
                    issue(KIND_SET_ACT, any_byte(), any_count(), 1'b1);
                end
                k = $urandom_range(1, 24);
                repeat (k) issue(KIND_WRITE, any_byte(), any_count(), any_flag());
                issue(KIND_PEEK, any_byte(),
                      ($urandom_range(0, 3) == 0) ? any_count()
                                                  : COUNT_W'($urandom_range(0, 70)),
                      any_flag());
                issue(KIND_ADVANCE, any_byte(), COUNT_W'($urandom_range(0, k + 8)),
                      any_flag());
            end else if (r < 88) begin
                issue_random_item();
            end else if (r < 95) begin
                issue(KIND_SET_ACT, any_byte(), any_count(), ($urandom_range(0, 4) != 0));
            end else begin
                issue(KIND_CLEAR, any_byte(), any_count(), any_flag());
            end
        end

        // Let the last beats drain, then look for stray results.
        start <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
